### rtl/core/sbus_mecanum_drive_mixer_core_macros.svh
// assertion macros for the s.bus mecanum mixer
// used by the checker, no other dependencies
`ifndef SBUS_MECANUM_DRIVE_MIXER_CORE_MACROS_SVH
`define SBUS_MECANUM_DRIVE_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define SMDM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smdm assertion failed");

// next-cycle implication
`define SMDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smdm assertion failed");

`endif

### rtl/core/smdm_pkg.sv
// shared types, constants and helpers of the s.bus mecanum mixer
// no dependencies
package smdm_pkg;

   localparam int POWER_FRACTION_BITS = 14;
   localparam int QUOT_W = POWER_FRACTION_BITS + 1;
   localparam int STEP_W = $clog2(POWER_FRACTION_BITS + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAFE = 2'd1;
   localparam logic [9:0] DEADBAND_RESET = 10'd60;
   localparam logic [10:0] STRAFE_RESET = 11'd1100;

   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE = 8'h00;
   localparam int FAILSAFE_BIT = 3;
   localparam logic [4:0] LAST_POS = 5'd24;
   localparam logic [4:0] FLAGS_POS = 5'd23;
   localparam logic [10:0] BUTTON_ON = 11'd1800;
   localparam logic [11:0] CHAN_MIN = 12'd200;
   localparam logic [19:0] UNIT_ONE = 20'd100000;
   localparam logic [10:0] PERMILLE_ONE = 11'd1000;

   localparam logic [1:0] STATUS_VALID = 2'd0;
   localparam logic [1:0] STATUS_RELEASED = 2'd1;
   localparam logic [1:0] STATUS_FAILSAFE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XMUL, ST_SUM, ST_NUM, ST_MAGA, ST_MAGB, ST_CMP, ST_DIV, ST_RND, ST_DONE
   } state_type;

   typedef struct packed {
      logic        done;
      logic        failsafe;
      logic [10:0] ch1;
      logic [10:0] ch2;
      logic [10:0] ch4;
      logic [10:0] ch6;
   } frame_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] front_left;
      logic [15:0] front_right;
      logic [15:0] rear_left;
      logic [15:0] rear_right;
   } result_type;

   // (ch - 200) / 8 truncated toward zero, minus 100
   function automatic logic signed [8:0] to_percent(input logic [10:0] ch);
      logic signed [11:0] t;
      logic [11:0] m;
      logic [8:0] q;
      t = $signed({1'b0, ch} - CHAN_MIN);
      m = t[11] ? 12'(-t) : 12'(t);
      q = 9'(m >> 3);
      to_percent = (t[11] ? -$signed(q) : $signed(q)) - 9'sd100;
   endfunction

   function automatic logic [19:0] mag21(input logic signed [20:0] v);
      mag21 = v[20] ? 20'(-v) : 20'(v);
   endfunction

endpackage

### rtl/core/smdm_frame_collect.sv
// s.bus frame collector: start-byte sync, byte capture, channel unpack
// depends on smdm_pkg
module smdm_frame_collect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output smdm_pkg::frame_type  frame
);
   import smdm_pkg::*;

   logic [4:0] pos_ff, pos_in;
   logic       done_ff, done_in;
   logic       fs_ff, fs_in;
   logic [7:0] bytes_ff [1:9];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         done_ff <= done_in;
      end
      fs_ff <= fs_in;
      if (accept && pos_ff >= 5'd1 && pos_ff <= 5'd9) begin
         bytes_ff[pos_ff[3:0]] <= rx_byte;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      done_in = 1'b0;
      fs_in = fs_ff;
      if (accept && !(pos_ff == 5'd0 && rx_byte != START_BYTE)) begin
         if (pos_ff == FLAGS_POS) fs_in = rx_byte[FAILSAFE_BIT];
         if (pos_ff == LAST_POS) begin
            pos_in = '0;
            done_in = (rx_byte == END_BYTE);
         end else begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   assign frame.done = done_ff;
   assign frame.failsafe = fs_ff;
   assign frame.ch1 = {bytes_ff[2][2:0], bytes_ff[1]};
   assign frame.ch2 = {bytes_ff[3][5:0], bytes_ff[2][7:3]};
   assign frame.ch4 = {bytes_ff[6][3:0], bytes_ff[5][7:1]};
   assign frame.ch6 = {bytes_ff[9][1:0], bytes_ff[8], bytes_ff[7][7]};

endmodule

### rtl/core/smdm_mix_unit.sv
// mecanum mix sequencer around one shared multiplier and compare-subtract
// depends on smdm_pkg
module smdm_mix_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  smdm_pkg::frame_type  frame,
   input  logic [9:0]           deadband,
   input  logic [10:0]          strafe,
   input  logic                 load_ok,
   output logic                 busy,
   output logic                 res_valid,
   output smdm_pkg::result_type res
);
   import smdm_pkg::*;

   state_type state_ff, state_in;
   logic signed [20:0] x_ff, y_ff, r_ff, n_ff;
   logic [19:0] d_ff;
   logic [31:0] pa_ff, pb_ff;
   logic [20:0] rem_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [STEP_W-1:0] step_ff;
   logic [1:0] wheel_ff;
   logic [1:0] status_ff;
   logic [15:0] pw_ff [4];

   logic signed [20:0] mul_a;
   logic [10:0] mul_b;
   logic signed [32:0] prod;
   logic [19:0] an, sum;
   logic [20:0] trial;
   logic ge;
   logic [QUOT_W:0] qr;
   logic [15:0] q16;

   assign prod = mul_a * $signed({1'b0, mul_b});
   assign an = mag21(n_ff);
   assign sum = mag21(x_ff) + mag21(y_ff) + mag21(r_ff);
   assign trial = (step_ff == '0) ? rem_ff : {rem_ff[19:0], 1'b0};
   assign ge = trial >= {1'b0, d_ff};
   assign qr = {1'b0, q_ff} + (QUOT_W + 1)'({rem_ff, 1'b0} >= {2'b0, d_ff});
   assign q16 = 16'(qr);

   always_comb begin
      mul_a = 21'(to_percent(frame.ch4));
      mul_b = strafe;
      case (state_ff)
         ST_MAGA: begin
            mul_a = $signed({1'b0, an});
            mul_b = PERMILLE_ONE;
         end
         ST_MAGB: begin
            mul_a = $signed({1'b0, d_ff});
            mul_b = {1'b0, deadband};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      case (state_ff)
         ST_IDLE: begin
            wheel_ff <= '0;
            for (int i = 0; i < 4; i++) pw_ff[i] <= '0;
            status_ff <= frame.failsafe ? STATUS_FAILSAFE :
                         (frame.ch6 != BUTTON_ON) ? STATUS_RELEASED : STATUS_VALID;
         end
         ST_XMUL: begin
            x_ff <= 21'(prod);
            y_ff <= -(21'(to_percent(frame.ch2)) * 21'sd1000);
            r_ff <= 21'(to_percent(frame.ch1)) * 21'sd1000;
         end
         ST_SUM: d_ff <= (sum > UNIT_ONE) ? sum : UNIT_ONE;
         ST_NUM: n_ff <= y_ff + ((wheel_ff == 2'd0 || wheel_ff == 2'd3) ? x_ff : -x_ff)
                          + ((wheel_ff == 2'd0 || wheel_ff == 2'd2) ? r_ff : -r_ff);
         ST_MAGA: pa_ff <= 32'(prod);
         ST_MAGB: pb_ff <= 32'(prod);
         ST_CMP: begin
            rem_ff <= {1'b0, an};
            q_ff <= '0;
            step_ff <= '0;
            if (pa_ff < pb_ff) begin
               pw_ff[wheel_ff] <= '0;
               wheel_ff <= wheel_ff + 2'd1;
            end
         end
         ST_DIV: begin
            rem_ff <= ge ? trial - {1'b0, d_ff} : trial;
            q_ff <= {q_ff[QUOT_W-2:0], ge};
            step_ff <= step_ff + 1'b1;
         end
         ST_RND: begin
            pw_ff[wheel_ff] <= n_ff[20] ? -q16 : q16;
            wheel_ff <= wheel_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (frame.done) begin
            state_in = (frame.failsafe || frame.ch6 != BUTTON_ON) ? ST_DONE : ST_XMUL;
         end
         ST_XMUL: state_in = ST_SUM;
         ST_SUM:  state_in = ST_NUM;
         ST_NUM:  state_in = ST_MAGA;
         ST_MAGA: state_in = ST_MAGB;
         ST_MAGB: state_in = ST_CMP;
         ST_CMP: begin
            if (pa_ff < pb_ff) state_in = (wheel_ff == 2'd3) ? ST_DONE : ST_NUM;
            else state_in = ST_DIV;
         end
         ST_DIV: if (step_ff == STEP_W'(POWER_FRACTION_BITS)) state_in = ST_RND;
         ST_RND:  state_in = (wheel_ff == 2'd3) ? ST_DONE : ST_NUM;
         ST_DONE: if (load_ok) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res.status = status_ff;
   assign res.front_left = pw_ff[0];
   assign res.front_right = pw_ff[1];
   assign res.rear_left = pw_ff[2];
   assign res.rear_right = pw_ff[3];

endmodule

### rtl/core/sbus_mecanum_drive_mixer_core.sv
// top level of the s.bus frame decoder with mecanum mixing
// depends on smdm_pkg, smdm_frame_collect, smdm_mix_unit
//
// channel | dir | contents
// req     | in  | tdata[7:0] rx_byte
// rsp     | out | tuser[1:0] drive_status, tdata 4 x 16 bit wheel powers
// csr     | in  | index 0 deadband_permille, index 1 strafe_gain_permille
//
// one byte per cycle while collecting; a good frame runs a setup pass, then each
// wheel in turn through the 15-step compare-subtract divider shared by the wheels;
// a wheel in the deadband skips the divider
// failsafe and released-button frames skip the mixing and go straight to done
// req_tready is low while the mixer is busy; a result waits in the rsp register
// synchronous active-high reset, no clearing pass
module sbus_mecanum_drive_mixer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,   // fl, fr, rl, rr power
   output logic [1:0]                         rsp_tuser,   // drive_status
   input  logic                               csr_we,
   input  logic [smdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [smdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import smdm_pkg::*;

   frame_type  frame;
   result_type res;
   logic busy, res_valid, load_ok;
   logic [9:0] deadband_ff;
   logic [10:0] strafe_ff;
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
         strafe_ff <= STRAFE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEADBAND: deadband_ff <= csr_wdata[9:0];
            CSR_STRAFE:   strafe_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign load_ok = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (res_valid && load_ok) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (res_valid && load_ok) begin
         rsp_data_ff <= {res.rear_right, res.rear_left, res.front_right, res.front_left};
         rsp_user_ff <= res.status;
      end
   end

   smdm_frame_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_tvalid && req_tready),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   smdm_mix_unit u_mix (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .deadband  (deadband_ff),
      .strafe    (strafe_ff),
      .load_ok   (load_ok),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res)
   );

   assign req_tready = !busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

### rtl/core/smdm_checker.sv
// port-level checks of the s.bus mecanum mixer, bound to the top level
// depends on smdm_pkg and sbus_mecanum_drive_mixer_core_macros.svh
`include "sbus_mecanum_drive_mixer_core_macros.svh"
module smdm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [63:0]                      rsp_tdata,
   input logic [1:0]                       rsp_tuser
);
   import smdm_pkg::*;

   `SMDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `SMDM_ASSERT_NOW(a_zero_when_not_valid, clock, reset,
      rsp_tvalid && rsp_tuser != STATUS_VALID, rsp_tdata == 64'd0)

   `SMDM_ASSERT_NOW(a_power_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata[15:0]) <= 16'sd16384 && $signed(rsp_tdata[15:0]) >= -16'sd16384 &&
      $signed(rsp_tdata[63:48]) <= 16'sd16384 && $signed(rsp_tdata[63:48]) >= -16'sd16384)

endmodule

bind sbus_mecanum_drive_mixer_core smdm_checker u_smdm_checker (.*);
